// ===== rtl/sgr_pkg.sv =====
// Package for the SGR attribute tracker: phase codes, SGR code constants,
// the 16-entry palette and the 256-colour index lookup.
// No dependencies.
package sgr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_MODE  = 3'd1,
      PH_INDEX = 3'd2,
      PH_RED   = 3'd3,
      PH_GREEN = 3'd4,
      PH_BLUE  = 3'd5
   } phase_type;

   typedef logic [23:0] rgb_type;

   localparam logic REG_DEFAULT_FG = 1'b0;
   localparam logic REG_DEFAULT_BG = 1'b1;

   localparam logic [15:0] SGR_RESET      = 16'd0;
   localparam logic [15:0] SGR_BOLD       = 16'd1;
   localparam logic [15:0] SGR_ITALIC     = 16'd3;
   localparam logic [15:0] SGR_UNDERLINE  = 16'd4;
   localparam logic [15:0] SGR_INVERSE    = 16'd7;
   localparam logic [15:0] SGR_FG_LO      = 16'd30;
   localparam logic [15:0] SGR_FG_HI      = 16'd37;
   localparam logic [15:0] SGR_EXT_FG     = 16'd38;
   localparam logic [15:0] SGR_BG_LO      = 16'd40;
   localparam logic [15:0] SGR_BG_HI      = 16'd47;
   localparam logic [15:0] SGR_EXT_BG     = 16'd48;
   localparam logic [15:0] SGR_FG_BRT_LO  = 16'd90;
   localparam logic [15:0] SGR_FG_BRT_HI  = 16'd97;
   localparam logic [15:0] SGR_BG_BRT_LO  = 16'd100;
   localparam logic [15:0] SGR_BG_BRT_HI  = 16'd107;
   localparam logic [15:0] EXT_MODE_TRUE  = 16'd2;
   localparam logic [15:0] EXT_MODE_INDEX = 16'd5;

   localparam logic [7:0] CUBE_FIRST      = 8'd16;
   localparam logic [7:0] CUBE_LAST       = 8'd231;
   localparam logic [7:0] CUBE_PLANE      = 8'd36;
   localparam logic [7:0] CUBE_STEP       = 8'd51;
   localparam logic [7:0] GREY_BASE_INDEX = 8'd232;
   localparam logic [7:0] GREY_BASE_LEVEL = 8'd8;
   localparam logic [7:0] GREY_STEP       = 8'd10;

   localparam rgb_type DEFAULT_FG_RESET = 24'hC0C0C0;
   localparam rgb_type DEFAULT_BG_RESET = 24'h000000;

   localparam rgb_type PALETTE [16] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
      24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   function automatic logic [7:0] sat8(input logic [15:0] v);
      return (v > 16'd255) ? 8'hFF : v[7:0];
   endfunction

   // k/36 as (k*57)>>11 and r/6 as (r*43)>>8, exact over the cube range
   function automatic rgb_type colour_of_index(input logic [15:0] n);
      logic [7:0]  k;
      logic [13:0] prod_r;
      logic [2:0]  cr;
      logic [7:0]  rem_w;
      logic [5:0]  rem;
      logic [11:0] prod_g;
      logic [2:0]  cg;
      logic [5:0]  cb_w;
      logic [2:0]  cb;
      logic [7:0]  grey;
      k      = n[7:0] - CUBE_FIRST;
      prod_r = 14'(k) * 14'd57;
      cr     = prod_r[13:11];
      rem_w  = k - 8'(cr) * CUBE_PLANE;
      rem    = rem_w[5:0];
      prod_g = 12'(rem) * 12'd43;
      cg     = prod_g[10:8];
      cb_w   = rem - 6'(cg) * 6'd6;
      cb     = cb_w[2:0];
      grey   = GREY_BASE_LEVEL + (n[7:0] - GREY_BASE_INDEX) * GREY_STEP;
      if (n < 16'(CUBE_FIRST)) begin
         return PALETTE[n[3:0]];
      end else if (n <= 16'(CUBE_LAST)) begin
         return {8'(cr) * CUBE_STEP, 8'(cg) * CUBE_STEP, 8'(cb) * CUBE_STEP};
      end else if (n <= 16'd255) begin
         return {grey, grey, grey};
      end else begin
         return 24'h000000;
      end
   endfunction

endpackage

// ===== rtl/sgr_attribute_tracker.sv =====
// SGR attribute tracker top level: decodes one SGR parameter per transfer
// and reports current colours and attributes. Depends on sgr_pkg.
// The result is registered: rsp valid rises in the cycle after the req transfer.
// Throughput: one parameter per cycle while the result is not stalled; the decode and index lookup sit
// between the request handshake and the result register.
// Reset (synchronous): defaults and colours to register reset values,
// attributes clear, no extended colour pending, result channel empty.
module sgr_attribute_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // param_value
   input  logic        req_tlast,   // param_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, attribute_bits, pad
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // unsupported_code
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sgr_pkg::*;

   rgb_type   def_fg_ff, def_bg_ff;
   rgb_type   fg_ff, fg_in, bg_ff, bg_in;
   logic [3:0] attr_ff, attr_in;
   phase_type phase_ff, phase_in;
   logic      tgt_bg_ff, tgt_bg_in;
   logic [7:0] pend_r_ff, pend_r_in, pend_g_ff, pend_g_in;
   logic      unsup;
   rgb_type   ext_colour;
   logic      ext_store;
   logic      rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic      rsp_user_ff;
   logic      req_xfer, csr_wr;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_DEFAULT_BG) ? {8'h00, def_bg_ff}
                                                        : {8'h00, def_fg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         def_fg_ff <= DEFAULT_FG_RESET;
         def_bg_ff <= DEFAULT_BG_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_DEFAULT_FG) begin
            def_fg_ff <= csr_pwdata[23:0];
         end else begin
            def_bg_ff <= csr_pwdata[23:0];
         end
      end
   end

   always_comb begin
      fg_in      = fg_ff;
      bg_in      = bg_ff;
      attr_in    = attr_ff;
      phase_in   = PH_IDLE;
      tgt_bg_in  = tgt_bg_ff;
      pend_r_in  = pend_r_ff;
      pend_g_in  = pend_g_ff;
      unsup      = 1'b0;
      ext_store  = 1'b0;
      ext_colour = colour_of_index(req_tdata);
      unique case (phase_ff)
         PH_MODE: begin
            if (req_tdata == EXT_MODE_INDEX) begin
               phase_in = PH_INDEX;
            end else if (req_tdata == EXT_MODE_TRUE) begin
               phase_in = PH_RED;
            end
         end
         PH_INDEX: begin
            ext_store = 1'b1;
         end
         PH_RED: begin
            pend_r_in = sat8(req_tdata);
            phase_in  = PH_GREEN;
         end
         PH_GREEN: begin
            pend_g_in = sat8(req_tdata);
            phase_in  = PH_BLUE;
         end
         PH_BLUE: begin
            ext_store  = 1'b1;
            ext_colour = {pend_r_ff, pend_g_ff, sat8(req_tdata)};
         end
         default: begin
            unique case (req_tdata) inside
               SGR_RESET: begin
                  fg_in   = def_fg_ff;
                  bg_in   = def_bg_ff;
                  attr_in = 4'h0;
               end
               SGR_BOLD:      attr_in = attr_ff | 4'b0001;
               SGR_ITALIC:    attr_in = attr_ff | 4'b0010;
               SGR_UNDERLINE: attr_in = attr_ff | 4'b0100;
               SGR_INVERSE:   attr_in = attr_ff | 4'b1000;
               SGR_EXT_FG, SGR_EXT_BG: begin
                  tgt_bg_in = (req_tdata == SGR_EXT_BG);
                  phase_in  = PH_MODE;
               end
               [SGR_FG_LO:SGR_FG_HI]:
                  fg_in = PALETTE[4'(req_tdata - SGR_FG_LO)];
               [SGR_FG_BRT_LO:SGR_FG_BRT_HI]:
                  fg_in = PALETTE[4'(req_tdata - SGR_FG_BRT_LO) + 4'd8];
               [SGR_BG_LO:SGR_BG_HI]:
                  bg_in = PALETTE[4'(req_tdata - SGR_BG_LO)];
               [SGR_BG_BRT_LO:SGR_BG_BRT_HI]:
                  bg_in = PALETTE[4'(req_tdata - SGR_BG_BRT_LO) + 4'd8];
               default: unsup = 1'b1;
            endcase
         end
      endcase
      if (ext_store) begin
         if (tgt_bg_ff) begin
            bg_in = ext_colour;
         end else begin
            fg_in = ext_colour;
         end
      end
      if (req_tlast) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= DEFAULT_FG_RESET;
         bg_ff        <= DEFAULT_BG_RESET;
         attr_ff      <= 4'h0;
         phase_ff     <= PH_IDLE;
         tgt_bg_ff    <= 1'b0;
         pend_r_ff    <= 8'h00;
         pend_g_ff    <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            fg_ff     <= fg_in;
            bg_ff     <= bg_in;
            attr_ff   <= attr_in;
            phase_ff  <= phase_in;
            tgt_bg_ff <= tgt_bg_in;
            pend_r_ff <= pend_r_in;
            pend_g_ff <= pend_g_in;
         end
         if (req_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= {4'h0, attr_in, bg_in[7:0], bg_in[15:8], bg_in[23:16],
                         fg_in[7:0], fg_in[15:8], fg_in[23:16]};
         rsp_user_ff <= unsup;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

   a_last_ends_ext: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> (phase_ff == PH_IDLE))
      else $error("extended colour still pending after last parameter");

   a_operand_supported: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && phase_ff != PH_IDLE) |=> !rsp_tuser)
      else $error("extended colour operand flagged unsupported");
`endif

endmodule
